@@ rtl/ble_adv_gateway_filter_defines.svh @@
// Assertion macros for the BLE advertisement gateway filter.
`ifndef BLE_ADV_GATEWAY_FILTER_DEFINES_SVH
`define BLE_ADV_GATEWAY_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define BAGF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bagf: check failed");
`define BAGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bagf: check failed");
`else
`define BAGF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BAGF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bagf_pkg.sv @@
// Types and constants of the BLE advertisement gateway filter.
package bagf_pkg;

    localparam int POS_W = 6;

    localparam logic [15:0] UUID_RESET = 16'h1122;
    localparam logic [47:0] NAME_RESET = 48'h7473_5450_4D53;

    localparam logic CFG_UUID16 = 1'b0;
    localparam logic CFG_NAME   = 1'b1;

    localparam logic [7:0] AD_UUID16_PART = 8'h02;
    localparam logic [7:0] AD_UUID16_CMPL = 8'h03;
    localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
    localparam logic [7:0] AD_NAME_CMPL   = 8'h09;

    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_NAME = 2'd1;
    localparam logic [1:0] REASON_UUID = 2'd2;

    localparam logic [7:0] ASCII_A_UP = 8'h41;
    localparam logic [7:0] ASCII_Z_UP = 8'h5A;
    localparam logic [7:0] ASCII_CASE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] adv_length;
        logic [4:0] scan_length;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic       is_gateway;
        logic [1:0] match_reason;
    } t_out_req;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= ASCII_A_UP && c <= ASCII_Z_UP) begin
            r = c + ASCII_CASE;
        end
        return r;
    endfunction

endpackage

@@ rtl/ble_adv_gateway_filter.sv @@
// Top level of the BLE advertisement gateway filter.
//
// Takes one advertisement byte per cycle (advertising part, then scan response) and,
// on the byte flagged last, delivers one request telling whether the advertisement
// names a gateway by device-name prefix (case-insensitive, complete name before
// short name) or by a 16-bit service UUID list entry. The structure walkers and name
// trackers handle each byte as it is accepted; a result passes through
// an output register backed by one skid stage, so input is stalled only while both
// hold undelivered results. Configuration writes are always ready.
`include "ble_adv_gateway_filter_defines.svh"

module ble_adv_gateway_filter
    import bagf_pkg::*;
#(
    parameter int PART_BYTES = 31,
    parameter int NAME_CHARS = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  t_in_req        i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output t_out_req       o_out_req,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [47:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(NAME_CHARS + 1);
    localparam logic [4:0] LEN_CLAMP = (PART_BYTES > 31) ? 5'd31 : 5'(PART_BYTES);
    localparam logic [CNT_W-1:0] NC_CNT = CNT_W'(NAME_CHARS);
    localparam logic [POS_W-1:0] NC_POS = POS_W'(NAME_CHARS);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic             seen;
        logic [POS_W-1:0] type_pos;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] count;
        logic             bad;
    } t_name_trk;

    function automatic t_name_trk name_step(input t_name_trk t, input logic [POS_W-1:0] p,
                                            input logic [7:0] b, input logic [63:0] nm);
        t_name_trk        nt;
        logic [POS_W-1:0] k;
        logic [7:0]       wc;
        nt = t;
        k  = p - t.type_pos - POS_W'(1);
        wc = '0;
        for (int j = 0; j < NAME_CHARS; j++) begin
            if (k == POS_W'(j)) begin
                wc = nm[8*(NAME_CHARS-1-j) +: 8];
            end
        end
        if (t.seen && p > t.type_pos && k < NC_POS && k < POS_W'(t.len)) begin
            if (to_lower(b) == to_lower(wc)) begin
                nt.count = t.count + CNT_W'(1);
            end else begin
                nt.bad = 1'b1;
            end
        end
        return nt;
    endfunction

    function automatic t_name_trk name_start(input t_name_trk t, input logic [POS_W-1:0] p,
                                             input logic [7:0] rem);
        t_name_trk  nt;
        logic [7:0] len;
        nt  = t;
        len = rem - 8'd1;
        if (!t.seen) begin
            nt.seen     = 1'b1;
            nt.type_pos = p;
            nt.len      = (len >= 8'(NAME_CHARS)) ? NC_CNT : len[CNT_W-1:0];
            nt.count    = '0;
            nt.bad      = 1'b0;
        end
        return nt;
    endfunction

    function automatic logic name_ok(input t_name_trk t);
        return t.len == NC_CNT && t.count == NC_CNT && !t.bad;
    endfunction

    // configuration
    logic [15:0] r_uuid, n_uuid;
    logic [47:0] r_name, n_name;

    // byte position and whole-advertisement walker
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_w_stop, n_w_stop;
    logic             r_w_tnext, n_w_tnext;
    logic [POS_W-1:0] r_w_hdr, n_w_hdr;
    logic [7:0]       r_w_rem, n_w_rem;
    t_name_trk        r_cmpl, n_cmpl;
    t_name_trk        r_short, n_short;

    // per-part walker
    logic             r_p_stop, n_p_stop;
    logic             r_p_tnext, n_p_tnext;
    logic [POS_W-1:0] r_p_hdr, n_p_hdr;
    logic [POS_W-1:0] r_p_lim, n_p_lim;
    logic [POS_W-1:0] r_p_rem, n_p_rem;
    logic [7:0]       r_p_type, n_p_type;
    logic [7:0]       r_u_low, n_u_low;
    logic             r_u_phase, n_u_phase;
    logic             r_u_found, n_u_found;

    // output register and skid stage
    logic     r_out_valid, n_out_valid;
    t_out_req r_out_req, n_out_req;
    logic     r_skid_valid, n_skid_valid;
    t_out_req r_skid_req, n_skid_req;

    logic             in_fire;
    logic             out_move;
    logic [4:0]       adv_c;
    logic [4:0]       scan_c;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] adv_pos;
    logic [POS_W-1:0] p;
    logic [7:0]       b;
    logic [63:0]      name64;
    logic [8:0]       w_sum;
    logic [POS_W:0]   p_next;
    logic [8:0]       p_end;
    logic             res_valid;
    t_out_req         res;
    logic             by_name;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_move = !r_out_valid || !i_out_stall;

    assign adv_c   = (i_in_req.adv_length > LEN_CLAMP) ? LEN_CLAMP : i_in_req.adv_length;
    assign scan_c  = (i_in_req.scan_length > LEN_CLAMP) ? LEN_CLAMP : i_in_req.scan_length;
    assign total   = POS_W'(adv_c) + POS_W'(scan_c);
    assign adv_pos = POS_W'(adv_c);
    assign p       = r_pos;
    assign b       = i_in_req.data_byte;
    assign name64  = {16'd0, r_name};

    always_comb begin
        n_uuid = r_uuid;
        n_name = r_name;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UUID16: n_uuid = i_cfg_data[15:0];
                CFG_NAME:   n_name = i_cfg_data;
                default:    n_name = r_name;
            endcase
        end

        n_pos     = r_pos;
        n_w_stop  = r_w_stop;
        n_w_tnext = r_w_tnext;
        n_w_hdr   = r_w_hdr;
        n_w_rem   = r_w_rem;
        n_cmpl    = r_cmpl;
        n_short   = r_short;
        n_p_stop  = r_p_stop;
        n_p_tnext = r_p_tnext;
        n_p_hdr   = r_p_hdr;
        n_p_lim   = r_p_lim;
        n_p_rem   = r_p_rem;
        n_p_type  = r_p_type;
        n_u_low   = r_u_low;
        n_u_phase = r_u_phase;
        n_u_found = r_u_found;
        w_sum     = 9'(p) + 9'(r_w_rem);
        p_next    = (POS_W+1)'(p) + (POS_W+1)'(1);
        p_end     = 9'(p_next) + 9'(b);

        if (in_fire && p < total) begin
            // part boundaries restart the per-part walker
            if (p == adv_pos) begin
                n_p_stop  = 1'b0;
                n_p_tnext = 1'b0;
                n_p_hdr   = adv_pos;
                n_p_lim   = total;
                n_p_type  = '0;
            end else if (p == '0) begin
                n_p_stop  = 1'b0;
                n_p_tnext = 1'b0;
                n_p_hdr   = '0;
                n_p_lim   = adv_pos;
                n_p_type  = '0;
            end

            n_cmpl  = name_step(r_cmpl, p, b, name64);
            n_short = name_step(r_short, p, b, name64);

            if (!r_w_stop) begin
                if (r_w_tnext) begin
                    if (b == AD_NAME_CMPL) begin
                        n_cmpl = name_start(n_cmpl, p, r_w_rem);
                    end else if (b == AD_NAME_SHORT) begin
                        n_short = name_start(n_short, p, r_w_rem);
                    end
                    n_w_hdr   = (w_sum > 9'(POS_MAX)) ? POS_MAX : w_sum[POS_W-1:0];
                    n_w_tnext = 1'b0;
                end else if (p == r_w_hdr) begin
                    if (b == '0) begin
                        n_w_stop = 1'b1;
                    end else begin
                        n_w_rem   = b;
                        n_w_tnext = 1'b1;
                    end
                end
            end

            if (!n_p_stop) begin
                if (n_p_tnext) begin
                    n_p_type  = b;
                    n_p_hdr   = p + n_p_rem;
                    n_u_phase = 1'b0;
                    n_p_tnext = 1'b0;
                end else if (p == n_p_hdr) begin
                    if (p_next >= (POS_W+1)'(n_p_lim) || b == '0 || p_end > 9'(n_p_lim)) begin
                        n_p_stop = 1'b1;
                    end else begin
                        n_p_rem   = b[POS_W-1:0];
                        n_p_tnext = 1'b1;
                    end
                end else if (n_p_type == AD_UUID16_PART || n_p_type == AD_UUID16_CMPL) begin
                    if (!r_u_phase) begin
                        n_u_low   = b;
                        n_u_phase = 1'b1;
                    end else begin
                        if ({b, r_u_low} == r_uuid) begin
                            n_u_found = 1'b1;
                        end
                        n_u_phase = 1'b0;
                    end
                end
            end
        end

        if (in_fire && r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end

        by_name = 1'b0;
        if (n_cmpl.seen && n_cmpl.len != '0) begin
            by_name = name_ok(n_cmpl);
        end else if (n_short.seen && n_short.len != '0) begin
            by_name = name_ok(n_short);
        end
        priority if (by_name) begin
            res.match_reason = REASON_NAME;
        end else if (n_u_found) begin
            res.match_reason = REASON_UUID;
        end else begin
            res.match_reason = REASON_NONE;
        end
        res.is_gateway = (res.match_reason != REASON_NONE);
        res_valid      = in_fire && i_in_req.last;

        if (res_valid) begin
            n_pos     = '0;
            n_w_stop  = 1'b0;
            n_w_tnext = 1'b0;
            n_w_hdr   = '0;
            n_w_rem   = '0;
            n_cmpl    = '0;
            n_short   = '0;
            n_p_stop  = 1'b1;
            n_p_tnext = 1'b0;
            n_p_hdr   = '0;
            n_p_lim   = '0;
            n_p_rem   = '0;
            n_p_type  = '0;
            n_u_low   = '0;
            n_u_phase = 1'b0;
            n_u_found = 1'b0;
        end

        n_out_valid  = r_out_valid;
        n_out_req    = r_out_req;
        n_skid_valid = r_skid_valid;
        n_skid_req   = r_skid_req;
        if (out_move) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_req    = r_skid_req;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_req   = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_req   = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid       <= UUID_RESET;
            r_name       <= NAME_RESET;
            r_pos        <= '0;
            r_w_stop     <= 1'b0;
            r_w_tnext    <= 1'b0;
            r_w_hdr      <= '0;
            r_w_rem      <= '0;
            r_cmpl       <= '0;
            r_short      <= '0;
            r_p_stop     <= 1'b1;
            r_p_tnext    <= 1'b0;
            r_p_hdr      <= '0;
            r_p_lim      <= '0;
            r_p_rem      <= '0;
            r_p_type     <= '0;
            r_u_low      <= '0;
            r_u_phase    <= 1'b0;
            r_u_found    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_uuid       <= n_uuid;
            r_name       <= n_name;
            r_pos        <= n_pos;
            r_w_stop     <= n_w_stop;
            r_w_tnext    <= n_w_tnext;
            r_w_hdr      <= n_w_hdr;
            r_w_rem      <= n_w_rem;
            r_cmpl       <= n_cmpl;
            r_short      <= n_short;
            r_p_stop     <= n_p_stop;
            r_p_tnext    <= n_p_tnext;
            r_p_hdr      <= n_p_hdr;
            r_p_lim      <= n_p_lim;
            r_p_rem      <= n_p_rem;
            r_p_type     <= n_p_type;
            r_u_low      <= n_u_low;
            r_u_phase    <= n_u_phase;
            r_u_found    <= n_u_found;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_req  <= n_out_req;
        r_skid_req <= n_skid_req;
    end

    `BAGF_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BAGF_ASSERT_IMPL(a_reason_flag, i_clk, i_rst_n, r_out_valid,
        (r_out_req.is_gateway == (r_out_req.match_reason != REASON_NONE)) &&
        (r_out_req.match_reason != 2'd3))
    `BAGF_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, in_fire && i_in_req.last,
        r_pos == '0 && r_p_stop && !r_u_found)

endmodule

@@ tb/tb.sv @@
// Testbench for the BLE advertisement gateway filter: a directed table, then random frames.
module tb;
    import bagf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREFIX_LEN = 6;
    localparam int POS_CAP    = 1023;
    localparam int DRAIN_CYC  = 8;
    localparam int QUIET_MAX  = 1000;

    typedef enum logic [1:0] {W_HDR, W_KIND, W_BODY, W_STOP} t_walk;

    typedef struct {
        bit seen;
        int at;
        int plen;
        int hits;
        bit miss;
    } t_name_trk;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_dir_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_req     in_req    = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = CFG_UUID16;
    logic [47:0] cfg_data  = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_req    out_req;
    logic        cfg_ready;

    // predictor state
    logic [15:0] want_uuid = UUID_RESET;
    logic [47:0] want_name = NAME_RESET;
    int          pos;
    t_walk       w_st, p_st;
    int          w_hdr, w_left, p_hdr, p_left, p_end;
    logic [7:0]  p_kind, pair_lo;
    bit          pair_half, uuid_hit;
    t_name_trk   full_nm, short_nm;

    t_out_req    gateway_verdicts[$];
    t_out_req    due;
    t_dir_row    plan[$];
    bit [7:0]    frame_q[$];
    int          fails      = 0;
    int          quiet      = 0;
    int          src_pct    = 0;
    int          sink_pct   = 0;
    int          live_items = 0;

    ble_adv_gateway_filter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void clear_adv();
        pos       = 0;
        w_st      = W_HDR;
        w_hdr     = 0;
        w_left    = 0;
        p_st      = W_STOP;
        p_hdr     = 0;
        p_left    = 0;
        p_end     = 0;
        p_kind    = '0;
        pair_lo   = '0;
        pair_half = 0;
        uuid_hit  = 0;
        full_nm   = '{default: 0};
        short_nm  = '{default: 0};
    endfunction

    function automatic logic [7:0] fold_lc(logic [7:0] c);
        return (c >= ASCII_A_UP && c <= ASCII_Z_UP) ? c + ASCII_CASE : c;
    endfunction

    function automatic void track_char(inout t_name_trk t, input int p, input logic [7:0] b);
        int k;
        if (!t.seen || p <= t.at) return;
        k = p - t.at - 1;
        if (k >= t.plen || k >= PREFIX_LEN) return;
        if (fold_lc(b) == fold_lc(want_name[8*(PREFIX_LEN-1-k) +: 8])) t.hits++;
        else t.miss = 1;
    endfunction

    function automatic void open_name(inout t_name_trk t, input int p, input int len);
        if (t.seen) return;
        t.seen = 1;
        t.at   = p;
        t.plen = len;
        t.hits = 0;
        t.miss = 0;
    endfunction

    function automatic bit name_hit(t_name_trk t);
        return t.plen >= PREFIX_LEN && t.hits >= PREFIX_LEN && !t.miss;
    endfunction

    // One advertisement byte; returns 1 when the byte closes the advertisement.
    function automatic bit scan_adv_byte(input t_in_req r, output t_out_req res);
        int         total;
        logic [7:0] b;
        bit         by_name;
        b     = r.data_byte;
        total = int'(r.adv_length) + int'(r.scan_length);
        res   = '0;
        if (pos < total) begin
            if (pos == r.adv_length) begin
                p_st   = W_HDR;
                p_hdr  = pos;
                p_end  = total;
                p_kind = '0;
            end else if (pos == 0) begin
                p_st   = W_HDR;
                p_hdr  = 0;
                p_end  = r.adv_length;
                p_kind = '0;
            end
            track_char(full_nm, pos, b);
            track_char(short_nm, pos, b);
            // structures over both parts, for names
            if (w_st == W_KIND) begin
                if (b == AD_NAME_CMPL) open_name(full_nm, pos, w_left - 1);
                else if (b == AD_NAME_SHORT) open_name(short_nm, pos, w_left - 1);
                w_hdr = pos + w_left;
                w_st  = W_BODY;
            end else if (w_st != W_STOP && pos == w_hdr) begin
                if (b == 0) begin
                    w_st = W_STOP;
                end else begin
                    w_left = b;
                    w_st   = W_KIND;
                end
            end
            // structures within the current part, for UUID lists
            if (p_st == W_KIND) begin
                p_kind    = b;
                p_hdr     = pos + p_left;
                pair_half = 0;
                p_st      = W_BODY;
            end else if (p_st != W_STOP && pos == p_hdr) begin
                if (pos + 1 >= p_end || b == 0 || pos + 1 + b > p_end) begin
                    p_st = W_STOP;
                end else begin
                    p_left = b;
                    p_st   = W_KIND;
                end
            end else if (p_st != W_STOP &&
                         (p_kind == AD_UUID16_PART || p_kind == AD_UUID16_CMPL)) begin
                if (!pair_half) begin
                    pair_lo   = b;
                    pair_half = 1;
                end else begin
                    if ({b, pair_lo} == want_uuid) uuid_hit = 1;
                    pair_half = 0;
                end
            end
        end
        if (pos < POS_CAP) pos++;
        if (!r.last) return 0;
        by_name = 0;
        if (full_nm.seen && full_nm.plen > 0) by_name = name_hit(full_nm);
        else if (short_nm.seen && short_nm.plen > 0) by_name = name_hit(short_nm);
        res.match_reason = by_name ? REASON_NAME : (uuid_hit ? REASON_UUID : REASON_NONE);
        res.is_gateway   = by_name || uuid_hit;
        clear_adv();
        return 1;
    endfunction

    function automatic void add_row(logic [7:0] d, logic [4:0] a, logic [4:0] s, logic l,
                                    bit typed = 0, logic [1:0] why = REASON_NONE);
        t_dir_row row;
        row.req   = '{d, a, s, l};
        row.typed = typed;
        row.want  = '{why != REASON_NONE, why};
        plan.push_back(row);
    endfunction

    // Appends n bytes of length-type structures, cut off at the part boundary.
    function automatic void add_part(int n);
        bit [7:0]    blk[$];
        int          k, plen, pairs, len;
        bit          odd;
        logic [15:0] u16;
        while (n > 0) begin
            blk.delete();
            case ($urandom_range(9))
                0, 1, 2: begin
                    plen = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(6, 8);
                    blk.push_back(8'(plen + 1));
                    blk.push_back($urandom_range(1) ? AD_NAME_CMPL : AD_NAME_SHORT);
                    for (k = 0; k < plen; k++) begin
                        if (k < PREFIX_LEN) begin
                            blk.push_back(want_name[8*(PREFIX_LEN-1-k) +: 8]);
                            if (fold_lc(blk[k+2]) != blk[k+2] ||
                                fold_lc(blk[k+2] ^ ASCII_CASE) != (blk[k+2] ^ ASCII_CASE))
                                if ($urandom_range(1)) blk[k+2] = blk[k+2] ^ ASCII_CASE;
                        end else begin
                            blk.push_back(8'($urandom));
                        end
                    end
                    if (plen > 0 && $urandom_range(4) == 0)
                        blk[2 + $urandom_range(plen - 1)] = 8'($urandom);
                end
                3, 4, 5: begin
                    pairs = $urandom_range(4);
                    odd   = ($urandom_range(3) == 0);
                    blk.push_back(8'(2 * pairs + odd + 1));
                    blk.push_back($urandom_range(1) ? AD_UUID16_CMPL : AD_UUID16_PART);
                    for (k = 0; k < pairs; k++) begin
                        u16 = ($urandom_range(2) == 0) ? want_uuid : 16'($urandom);
                        blk.push_back(u16[7:0]);
                        blk.push_back(u16[15:8]);
                    end
                    if (odd) blk.push_back(8'($urandom));
                end
                6: begin
                    len = $urandom_range(1, 5);
                    blk.push_back(8'(len));
                    for (k = 0; k < len; k++) blk.push_back(8'($urandom));
                end
                7: blk.push_back(8'h00);
                8: begin
                    // structure overrunning the part
                    blk.push_back(8'(n + $urandom_range(4)));
                    for (k = 1; k < n; k++) blk.push_back(8'($urandom));
                end
                default: blk.push_back(8'($urandom));
            endcase
            for (k = 0; k < blk.size() && n > 0; k++) begin
                frame_q.push_back(blk[k]);
                n--;
            end
        end
    endfunction

    task automatic send_req(input t_in_req r, input bit typed, input t_out_req want);
        t_out_req guess;
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        live_items++;
        if (scan_adv_byte(r, guess)) gateway_verdicts.push_back(typed ? want : guess);
    endtask

    task automatic run_frame();
        logic [4:0] a, s;
        int         tot, cnt, mode, k;
        t_in_req    r;
        a = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(12));
        s = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(12));
        frame_q.delete();
        add_part(a);
        add_part(s);
        tot  = a + s;
        mode = $urandom_range(9);
        cnt  = (tot == 0) ? 1 : tot;
        if (mode == 7) cnt = $urandom_range(1, cnt);
        else if (mode == 8) cnt = cnt + $urandom_range(1, ($urandom_range(3) == 0) ? 80 : 8);
        else if (mode == 9) cnt = $urandom_range(1, 40);
        for (k = 0; k < cnt; k++) begin
            r.data_byte   = (mode != 9 && k < frame_q.size()) ? frame_q[k] : 8'($urandom);
            r.adv_length  = (mode == 9 && $urandom_range(1)) ? 5'($urandom) : a;
            r.scan_length = (mode == 9 && $urandom_range(1)) ? 5'($urandom) : s;
            r.last        = (k == cnt - 1);
            send_req(r, 0, '0);
        end
    endtask

    task automatic write_regs(input logic [15:0] u, input logic [47:0] nm);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_UUID16;
        cfg_data  <= {32'h0, u};
        do @(posedge clk); while (!cfg_ready);
        want_uuid = u;
        cfg_index <= CFG_NAME;
        cfg_data  <= nm;
        do @(posedge clk); while (!cfg_ready);
        want_name = nm;
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (gateway_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (gateway_verdicts.size() == 0) begin
                $error("unexpected request: is_gateway %0d match_reason %0d",
                       out_req.is_gateway, out_req.match_reason);
                fails++;
            end else begin
                due = gateway_verdicts.pop_front();
                if (out_req.is_gateway !== due.is_gateway) begin
                    $error("is_gateway: expected %0d, got %0d",
                           due.is_gateway, out_req.is_gateway);
                    fails++;
                end
                if (out_req.match_reason !== due.match_reason) begin
                    $error("match_reason: expected %0d, got %0d",
                           due.match_reason, out_req.match_reason);
                    fails++;
                end
            end
        end
        out_stall <= (sink_pct != 0) && ($urandom_range(99) < sink_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] u;
        logic [47:0] nm;
        int          ph, k, frames;
        clear_adv();
        // empty advertisement, oversized and zero headers on an early last
        add_row(8'h00, 5'd0, 5'd0, 1'b1, 1, REASON_NONE);
        add_row(8'hFF, 5'd31, 5'd31, 1'b1, 1, REASON_NONE);
        add_row(8'h00, 5'd31, 5'd31, 1'b1, 1, REASON_NONE);
        // complete 16-bit UUID list in the advertising part
        add_row(8'h03, 5'd4, 5'd0, 1'b0);
        add_row(AD_UUID16_CMPL, 5'd4, 5'd0, 1'b0);
        add_row(UUID_RESET[7:0], 5'd4, 5'd0, 1'b0);
        add_row(UUID_RESET[15:8], 5'd4, 5'd0, 1'b1, 1, REASON_UUID);
        // complete name, every letter in the other case
        add_row(8'h07, 5'd8, 5'd0, 1'b0);
        add_row(AD_NAME_CMPL, 5'd8, 5'd0, 1'b0);
        for (k = PREFIX_LEN - 1; k > 0; k--)
            add_row(NAME_RESET[8*k +: 8] ^ ASCII_CASE, 5'd8, 5'd0, 1'b0);
        add_row(NAME_RESET[7:0] ^ ASCII_CASE, 5'd8, 5'd0, 1'b1, 1, REASON_NAME);
        // partial UUID list in the scan response, odd trailing byte
        add_row(8'h04, 5'd0, 5'd5, 1'b0);
        add_row(AD_UUID16_PART, 5'd0, 5'd5, 1'b0);
        add_row(UUID_RESET[7:0], 5'd0, 5'd5, 1'b0);
        add_row(UUID_RESET[15:8], 5'd0, 5'd5, 1'b0);
        add_row(8'h00, 5'd0, 5'd5, 1'b1, 1, REASON_UUID);
        // byte past the declared lengths
        add_row(8'h00, 5'd1, 5'd0, 1'b0);
        add_row(8'hAA, 5'd1, 5'd0, 1'b1, 1, REASON_NONE);
        // short name too short to match
        add_row(8'h02, 5'd0, 5'd3, 1'b0);
        add_row(AD_NAME_SHORT, 5'd0, 5'd3, 1'b0);
        add_row(NAME_RESET[47:40], 5'd0, 5'd3, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph % 4)
                0: begin src_pct = 0;  sink_pct = 0;  end
                1: begin src_pct = 47; sink_pct = 0;  end
                2: begin src_pct = 0;  sink_pct = 47; end
                default: begin src_pct = 6; sink_pct = 6; end
            endcase
            case (ph)
                0: begin u = '0; nm = '0; end
                1: begin u = '1; nm = '1; end
                default: begin
                    u = 16'($urandom);
                    for (k = 0; k < PREFIX_LEN; k++)
                        nm[8*k +: 8] = ($urandom_range(3) != 0) ?
                            (8'($urandom_range(ASCII_A_UP, ASCII_Z_UP)) |
                             ($urandom_range(1) ? ASCII_CASE : 8'h00)) :
                            8'($urandom);
                end
            endcase
            write_regs(u, nm);
            live_items = 0;
            frames     = 0;
            while (live_items < 108 || frames < 8) begin
                run_frame();
                frames++;
            end
        end
        settle();
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ ble_adv_gateway_filter.f @@
+incdir+rtl
rtl/bagf_pkg.sv
rtl/ble_adv_gateway_filter.sv
tb/tb.sv
